// ----- rtl/core/arfp_pkg.sv -----
// Shared types and codes for the audio ring frame packetizer.
package arfp_pkg;

  localparam int unsigned FLEN_W  = 6;
  localparam int unsigned SPACE_W = 13;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_FRAME   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_WRITE_ACK   = 2'd0,
    KIND_FRAME_BYTE  = 2'd1,
    KIND_RESTART_ACK = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRAME,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         out_byte;
    logic               accepted;
    logic               silence;
    logic [FLEN_W-1:0]  frame_len;
    logic               last;
    logic [SPACE_W-1:0] free_space;
  } out_item_t;

  typedef struct packed {
    logic wr_adv;
    logic rd_adv;
    logic clear;
  } ptr_op_t;

endpackage

// ----- rtl/core/arfp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module arfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/arfp_ptr.sv -----
// Ring pointers and fill count, advanced through one shared wrap incrementer.
module arfp_ptr
  import arfp_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 8192
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptr_op_t                       op,
  output logic [$clog2(RING_DEPTH)-1:0] wr_ptr,
  output logic [$clog2(RING_DEPTH)-1:0] rd_ptr,
  output logic [$clog2(RING_DEPTH)-1:0] held
);

  localparam int unsigned AW = $clog2(RING_DEPTH);

  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [AW-1:0] held_r, held_nxt;
  logic [AW-1:0] sel;
  logic [AW-1:0] bumped;

  // Only one pointer moves in any cycle, so one incrementer serves both.
  assign sel    = op.rd_adv ? rd_r : wr_r;
  assign bumped = (sel == AW'(RING_DEPTH - 1)) ? '0 : sel + 1'b1;

  always_comb begin
    wr_nxt   = wr_r;
    rd_nxt   = rd_r;
    held_nxt = held_r;
    if (op.clear) begin
      wr_nxt   = '0;
      rd_nxt   = '0;
      held_nxt = '0;
    end else if (op.rd_adv) begin
      rd_nxt   = bumped;
      held_nxt = held_r - 1'b1;
    end else if (op.wr_adv) begin
      wr_nxt   = bumped;
      held_nxt = held_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      held_r <= '0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      held_r <= held_nxt;
    end
  end

  assign wr_ptr = wr_r;
  assign rd_ptr = rd_r;
  assign held   = held_r;

endmodule

// ----- rtl/core/audio_ring_frame_packetizer.sv -----
// Top level of the audio ring frame packetizer: command sequencer and result register.
//
//   channel   ports                      transfer when
//   input     start, busy, in_item       start high and busy low at a clock edge
//   result    out_valid, out_item        out_valid high for one cycle, always taken
//
// A write or restart leaves busy low; its result is out in the cycle after the transfer.
// A frame request keeps busy high through ST_FRAME and ST_DRAIN: one RAM read is issued
// per cycle through the single read port, and ST_DRAIN covers the registered read.
// Frame bytes follow one per cycle; each is read into the RAM read register, then into out_r.
// Synchronous reset clears both pointers and the fill count; the ring store is not cleared.
// The receiver cannot stall, so results are never held back.
module audio_ring_frame_packetizer
  import arfp_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = 8192,
  parameter int unsigned FRAME_BYTES = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int unsigned AW  = $clog2(RING_DEPTH);
  localparam int unsigned CNW = $clog2(FRAME_BYTES + 1);

  state_t state_r, state_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic sil_r, sil_nxt;
  logic [FLEN_W-1:0] flen_r, flen_nxt;
  logic [SPACE_W-1:0] space_r, space_nxt;
  logic pend_r, pend_nxt;
  logic pend_last_r, pend_last_nxt;
  out_item_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  ptr_op_t ptr_op;
  logic ram_we;
  logic [AW-1:0] wr_ptr, rd_ptr, held;
  logic [7:0] rdata;

  logic [31:0] held_w;
  logic [31:0] free_w;
  logic [31:0] len_w;
  logic [31:0] wr_space_w;
  logic [31:0] fr_space_w;
  logic [31:0] rs_space_w;
  logic room;
  logic empty;

  arfp_ptr #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ptr (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (ptr_op),
    .wr_ptr (wr_ptr),
    .rd_ptr (rd_ptr),
    .held   (held)
  );

  arfp_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (in_item.data_byte),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  assign held_w     = 32'(held);
  assign free_w     = 32'(RING_DEPTH - 1) - held_w;
  assign room       = (free_w != 32'd0);
  assign empty      = (held_w == 32'd0);
  assign len_w      = empty ? 32'(FRAME_BYTES)
                    : ((held_w < 32'(FRAME_BYTES)) ? held_w : 32'(FRAME_BYTES));
  assign wr_space_w = room ? (free_w - 32'd1) : free_w;
  assign fr_space_w = empty ? free_w : (free_w + len_w);
  assign rs_space_w = 32'(RING_DEPTH - 1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sil_nxt       = sil_r;
    flen_nxt      = flen_r;
    space_nxt     = space_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = 1'b0;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    ptr_op        = '0;
    ram_we        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_item.cmd)
            CMD_WRITE: begin
              ram_we         = room;
              ptr_op.wr_adv  = room;
              out_nxt        = '0;
              out_nxt.kind   = KIND_WRITE_ACK;
              out_nxt.accepted   = room;
              out_nxt.last       = 1'b1;
              out_nxt.free_space = wr_space_w[SPACE_W-1:0];
              out_valid_nxt  = 1'b1;
            end
            CMD_FRAME: begin
              sil_nxt   = empty;
              flen_nxt  = len_w[FLEN_W-1:0];
              space_nxt = fr_space_w[SPACE_W-1:0];
              cnt_nxt   = len_w[CNW-1:0];
              state_nxt = ST_FRAME;
            end
            CMD_RESTART: begin
              ptr_op.clear       = 1'b1;
              out_nxt            = '0;
              out_nxt.kind       = KIND_RESTART_ACK;
              out_nxt.last       = 1'b1;
              out_nxt.free_space = rs_space_w[SPACE_W-1:0];
              out_valid_nxt      = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FRAME: begin
        pend_nxt      = 1'b1;
        pend_last_nxt = (cnt_r == CNW'(1));
        ptr_op.rd_adv = !sil_r;
        cnt_nxt       = cnt_r - 1'b1;
        if (cnt_r == CNW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (pend_r) begin
      out_nxt.kind       = KIND_FRAME_BYTE;
      out_nxt.out_byte   = sil_r ? 8'd0 : rdata;
      out_nxt.accepted   = 1'b0;
      out_nxt.silence    = sil_r;
      out_nxt.frame_len  = flen_r;
      out_nxt.last       = pend_last_r;
      out_nxt.free_space = space_r;
      out_valid_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    sil_r       <= sil_nxt;
    flen_r      <= flen_nxt;
    space_r     <= space_nxt;
    pend_last_r <= pend_last_nxt;
    out_r       <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- tb/arfp_frame_checker.sv -----
// Result checker for the audio ring frame packetizer: ring predictor and in-order compare.
module arfp_frame_checker
  import arfp_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = 8192,
  parameter int unsigned FRAME_BYTES = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        errors,
  output int        pending,
  output int        commands_seen,
  output int        results_seen,
  output int        refused_writes,
  output int        silent_frames
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  ring_mem [RING_DEPTH];
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  out_item_t   expected_results [$];
  int          mismatches;
  int          n_commands;
  int          n_results;
  int          n_refused;
  int          n_silent;

  function automatic int unsigned bytes_held();
    return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
  endfunction

  function automatic int unsigned slots_free();
    return RING_DEPTH - 1 - bytes_held();
  endfunction

  function automatic int unsigned next_slot(input int unsigned ptr);
    return (ptr + 1 == RING_DEPTH) ? 0 : ptr + 1;
  endfunction

  function automatic out_item_t make_result(input kind_t kind, input logic [7:0] data,
                                            input logic acc, input logic sil,
                                            input int unsigned flen, input logic fin);
    out_item_t r;
    r.kind       = kind;
    r.out_byte   = data;
    r.accepted   = acc;
    r.silence    = sil;
    r.frame_len  = FLEN_W'(flen);
    r.last       = fin;
    r.free_space = SPACE_W'(slots_free());
    return r;
  endfunction

  task automatic predict_command(input in_item_t item);
    logic [7:0]  frame_data [FRAME_BYTES];
    int unsigned len;
    logic        sil;
    logic        acc;
    case (item.cmd)
      CMD_WRITE: begin
        acc = 1'b0;
        if (slots_free() > 0) begin
          ring_mem[wr_ptr] = item.data_byte;
          wr_ptr = next_slot(wr_ptr);
          acc = 1'b1;
        end else begin
          n_refused++;
        end
        expected_results.push_back(make_result(KIND_WRITE_ACK, 8'h00, acc, 1'b0, 0, 1'b1));
        n_commands++;
      end
      CMD_FRAME: begin
        len = bytes_held();
        if (len > FRAME_BYTES) len = FRAME_BYTES;
        sil = (len == 0);
        if (sil) begin
          len = FRAME_BYTES;
          n_silent++;
        end
        for (int unsigned i = 0; i < len; i++) begin
          if (sil) begin
            frame_data[i] = 8'h00;
          end else begin
            frame_data[i] = ring_mem[rd_ptr];
            rd_ptr = next_slot(rd_ptr);
          end
        end
        for (int unsigned i = 0; i < len; i++) begin
          expected_results.push_back(make_result(KIND_FRAME_BYTE, frame_data[i], 1'b0, sil,
                                                 len, i + 1 == len));
        end
        n_commands++;
      end
      CMD_RESTART: begin
        wr_ptr = 0;
        rd_ptr = 0;
        expected_results.push_back(make_result(KIND_RESTART_ACK, 8'h00, 1'b0, 1'b0, 0, 1'b1));
        n_commands++;
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input out_item_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, what);
      $display("  expected kind=%0d byte=%02h acc=%b sil=%b len=%0d last=%b free=%0d",
               want.kind, want.out_byte, want.accepted, want.silence, want.frame_len,
               want.last, want.free_space);
      $display("  actual   kind=%0d byte=%02h acc=%b sil=%b len=%0d last=%b free=%0d",
               out_item.kind, out_item.out_byte, out_item.accepted, out_item.silence,
               out_item.frame_len, out_item.last, out_item.free_space);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      wr_ptr = 0;
      rd_ptr = 0;
      expected_results.delete();
      mismatches = 0;
      n_commands = 0;
      n_results  = 0;
      n_refused  = 0;
      n_silent   = 0;
    end else begin
      if (start && !busy) predict_command(in_item);
      if (out_valid) begin
        n_results++;
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with nothing expected", '0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.kind !== want.kind || out_item.out_byte !== want.out_byte ||
              out_item.accepted !== want.accepted || out_item.silence !== want.silence ||
              out_item.frame_len !== want.frame_len || out_item.last !== want.last ||
              out_item.free_space !== want.free_space) begin
            report_mismatch("result transfer does not match", want);
          end
        end
      end
    end
    errors         <= mismatches;
    pending        <= expected_results.size();
    commands_seen  <= n_commands;
    results_seen   <= n_results;
    refused_writes <= n_refused;
    silent_frames  <= n_silent;
  end

endmodule

// ----- tb/audio_ring_frame_packetizer_tb.sv -----
// Testbench top for the audio ring frame packetizer: clock, reset, command stimulus, verdict.
module audio_ring_frame_packetizer_tb
  import arfp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_DEPTH    = 8192;
  localparam int unsigned FRAME_BYTES   = 32;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = FRAME_BYTES + 8;
  localparam int          RANDOM_ITEMS  = 380;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  int          errors;
  int          pending;
  int          commands_seen;
  int          results_seen;
  int          refused_writes;
  int          silent_frames;
  int unsigned stall_cycles = 0;
  bit          quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  audio_ring_frame_packetizer #(
    .RING_DEPTH (RING_DEPTH),
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  arfp_frame_checker #(
    .RING_DEPTH (RING_DEPTH),
    .FRAME_BYTES(FRAME_BYTES)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .errors        (errors),
    .pending       (pending),
    .commands_seen (commands_seen),
    .results_seen  (results_seen),
    .refused_writes(refused_writes),
    .silent_frames (silent_frames)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("audio_ring_frame_packetizer verification failed");
      $finish;
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [7:0] data);
    if (!quiet && $urandom_range(99) < 32) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 32);
    end
    in_item <= '{cmd: cmd, data_byte: data};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Hold off new commands until every expected result has been seen.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int pick;
    int burst;
    int random_items;
    random_items = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(CMD_RESTART, 8'hFF);
    send(CMD_FRAME, 8'h00);
    send(CMD_WRITE, 8'h00);
    send(CMD_WRITE, 8'hFF);
    send(CMD_WRITE, 8'hA5);
    send(CMD_WRITE, 8'h5A);
    send(CMD_FRAME, 8'hFF);
    send(CMD_UNUSED, 8'hC3);
    send(CMD_FRAME, 8'h00);
    repeat (3) send(CMD_WRITE, 8'($urandom_range(255)));
    send(CMD_UNUSED, 8'h3C);
    send(CMD_RESTART, 8'h00);
    send(CMD_FRAME, 8'h00);
    send(CMD_WRITE, 8'h81);
    send(CMD_FRAME, 8'h7E);
    settle();

    // Back-to-back writes with no idle cycles, then frames that drain them.
    quiet = 1'b1;
    repeat (48) send(CMD_WRITE, 8'($urandom_range(255)));
    repeat (2) send(CMD_FRAME, 8'($urandom_range(255)));
    quiet = 1'b0;
    settle();

    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        burst = $urandom_range(1, 48);
        repeat (burst) send(CMD_WRITE, 8'($urandom_range(255)));
        random_items += burst;
      end else if (pick < 86) begin
        send(CMD_FRAME, 8'($urandom_range(255)));
        random_items++;
      end else if (pick < 92) begin
        send(CMD_RESTART, 8'($urandom_range(255)));
        random_items++;
      end else if (pick < 95) begin
        settle();
      end else begin
        send(CMD_UNUSED, 8'($urandom_range(255)));
      end
    end
    settle();

    $display("Run covered %0d commands and %0d result transfers, with %0d refused writes",
             commands_seen, results_seen, refused_writes);
    $display("and %0d underrun frames, along with partial frames, unused codes and restarts.",
             silent_frames);
    if (errors == 0 && pending == 0) begin
      $display("audio_ring_frame_packetizer verification clean");
    end else begin
      $display("audio_ring_frame_packetizer verification failed");
    end
    $finish;
  end

endmodule
